// ===== rtl/euler_angles_to_rotation_axes_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Euler angle to rotation axes block
// Shared concurrent assertion forms.
// ---------------------------------------------------------------------------
`ifndef EULER_ANGLES_TO_ROTATION_AXES_TOP_MACROS_SVH
`define EULER_ANGLES_TO_ROTATION_AXES_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define EATRA_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, off during reset
`define EATRA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// next-cycle implication, also active across reset
`define EATRA_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

// ===== rtl/eatra_pkg.sv =====
// ---------------------------------------------------------------------------
// eatra_pkg
// Types, constants and helper functions for the rotation axes pipeline.
// ---------------------------------------------------------------------------
package eatra_pkg;

  localparam int ATAN_ENTRIES = 24;

  // angle reduction: 23040 units per turn
  localparam logic [17:0] TURN_UNITS  = 18'd23040;
  localparam logic [17:0] TWO_TURNS   = 18'd46080;

  // phase = floor((a*2^23 + 22) / 45), split as a*186413 + floor((23a+22)/45)
  localparam logic [32:0] PH_MUL_HI   = 33'd186413;
  localparam logic [19:0] PH_REM_MUL  = 20'd23;
  localparam logic [19:0] PH_BIAS     = 20'd22;
  localparam logic [40:0] PH_RECIP    = 41'd1491309;
  localparam int          PH_SHIFT    = 26;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef logic signed [31:0] trig_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sincos_t;

  // first field in the highest bits
  typedef struct packed {
    logic signed [15:0] fwd_z;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_x;
    logic signed [15:0] up_z;
    logic signed [15:0] up_y;
    logic signed [15:0] up_x;
    logic signed [15:0] left_z;
    logic signed [15:0] left_y;
    logic signed [15:0] left_x;
  } axes_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic signed [31:0] atan_step(input int idx);
    case (idx)
      0:  return 32'sd536870912;
      1:  return 32'sd316933406;
      2:  return 32'sd167458907;
      3:  return 32'sd85004756;
      4:  return 32'sd42667331;
      5:  return 32'sd21354465;
      6:  return 32'sd10679838;
      7:  return 32'sd5340245;
      8:  return 32'sd2670163;
      9:  return 32'sd1335087;
      10: return 32'sd667544;
      11: return 32'sd333772;
      12: return 32'sd166886;
      13: return 32'sd83443;
      14: return 32'sd41722;
      15: return 32'sd20861;
      16: return 32'sd10430;
      17: return 32'sd5215;
      18: return 32'sd2608;
      19: return 32'sd1304;
      20: return 32'sd652;
      21: return 32'sd326;
      22: return 32'sd163;
      23: return 32'sd81;
      default: return 32'sd0;
    endcase
  endfunction

  // Q.60 -> Q1.15, round half up, saturate
  function automatic logic signed [15:0] to_q15(input logic signed [65:0] v);
    logic signed [65:0] t;
    logic signed [20:0] r;
    t = v + 66'sd17592186044416;
    r = 21'(t >>> 45);
    if (r > 21'sd32767) begin
      return 16'sh7fff;
    end else if (r < -21'sd32768) begin
      return 16'sh8000;
    end else begin
      return r[15:0];
    end
  endfunction

endpackage

// ===== rtl/eatra_phase.sv =====
// ---------------------------------------------------------------------------
// eatra_phase
// Reduces an angle in 1/64 degree modulo a turn, scales to a 32-bit phase.
// ---------------------------------------------------------------------------
module eatra_phase (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  output logic [31:0]        phase
);

  localparam int PH_SHIFT_TOP = eatra_pkg::PH_SHIFT + 14;

  logic [17:0] wrap0, wrap1, red;
  logic [14:0] ang_r;
  logic        v1, v2;
  logic [32:0] hi_prod;
  logic [19:0] rem_x;
  logic [40:0] lo_prod;
  logic [31:0] hi_r;
  logic [14:0] lo_r;

  // bias by two turns so the value is never negative, then fold twice
  always_comb begin
    wrap0 = 18'($signed({{2{angle[15]}}, angle}) + $signed(eatra_pkg::TWO_TURNS));
    wrap1 = (wrap0 >= eatra_pkg::TWO_TURNS) ? wrap0 - eatra_pkg::TWO_TURNS : wrap0;
    red   = (wrap1 >= eatra_pkg::TURN_UNITS) ? wrap1 - eatra_pkg::TURN_UNITS : wrap1;
  end

  always_comb begin
    hi_prod = {18'd0, ang_r} * eatra_pkg::PH_MUL_HI;
    rem_x   = {5'd0, ang_r} * eatra_pkg::PH_REM_MUL + eatra_pkg::PH_BIAS;
    lo_prod = {21'd0, rem_x} * eatra_pkg::PH_RECIP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= red[14:0];
      hi_r  <= hi_prod[31:0];
      lo_r  <= lo_prod[PH_SHIFT_TOP:eatra_pkg::PH_SHIFT];
      phase <= hi_r + {17'd0, lo_r};
    end
  end

endmodule

// ===== rtl/eatra_cordic.sv =====
// ---------------------------------------------------------------------------
// eatra_cordic
// Unrolled rotation-mode CORDIC, one step per register stage, then quadrant.
// ---------------------------------------------------------------------------
module eatra_cordic #(
  parameter int STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       phase,
  output logic              out_valid,
  output eatra_pkg::sincos_t result
);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  logic signed [33:0] xs [STEPS];
  logic signed [33:0] ys [STEPS];
  logic signed [31:0] zs [STEPS];
  logic [1:0]         qs [STEPS];
  logic               vs [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [33:0] xi, yi;
    logic signed [31:0] zi;
    logic [1:0]         qi;
    logic               vi;

    if (k == 0) begin : g_first
      assign xi = eatra_pkg::CORDIC_GAIN_Q30;
      assign yi = 34'sd0;
      assign zi = $signed({2'b00, phase[29:0]});
      assign qi = phase[31:30];
      assign vi = in_valid;
    end else begin : g_next
      assign xi = xs[k-1];
      assign yi = ys[k-1];
      assign zi = zs[k-1];
      assign qi = qs[k-1];
      assign vi = vs[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qs[k] <= qi;
        if (!zi[31]) begin
          xs[k] <= xi - (yi >>> k);
          ys[k] <= yi + (xi >>> k);
          zs[k] <= zi - eatra_pkg::atan_step(k);
        end else begin
          xs[k] <= xi + (yi >>> k);
          ys[k] <= yi - (xi >>> k);
          zs[k] <= zi + eatra_pkg::atan_step(k);
        end
      end
    end
  end

  logic signed [33:0] xf, yf, nc, ns;

  assign xf = xs[STEPS-1];
  assign yf = ys[STEPS-1];

  always_comb begin
    case (qs[STEPS-1])
      QUAD_I:   begin nc = xf;  ns = yf;  end
      QUAD_II:  begin nc = -yf; ns = xf;  end
      QUAD_III: begin nc = -xf; ns = -yf; end
      default:  begin nc = yf;  ns = -xf; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.c <= nc[31:0];
      result.s <= ns[31:0];
    end
  end

endmodule

// ===== rtl/eatra_matrix.sv =====
// ---------------------------------------------------------------------------
// eatra_matrix
// Four-stage product pipeline forming the X-Y-Z rotation matrix columns.
// ---------------------------------------------------------------------------
module eatra_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  eatra_pkg::sincos_t rx,
  input  eatra_pkg::sincos_t ry,
  input  eatra_pkg::sincos_t rz,
  output logic               out_valid,
  output eatra_pkg::axes_t   axes
);

  logic v1, v2, v3;

  // stage 1: pair products
  logic signed [63:0] sxsy1, cxsy1, cycz1, cysz1, sxcy1, cxcy1;
  logic signed [63:0] sxsz1, cxcz1, sxcz1, cxsz1;
  logic signed [31:0] sy1, cz1, sz1;

  // stage 2: rounded pairs
  logic signed [33:0] sxsy2, cxsy2;
  logic signed [63:0] cycz2, cysz2, sxcy2, cxcy2, sxsz2, cxcz2, sxcz2, cxsz2;
  logic signed [31:0] sy2, cz2, sz2;
  logic signed [63:0] sxsy_rt, cxsy_rt;

  // stage 3: triple products
  logic signed [65:0] sxsycz3, sxsysz3, cxsycz3, cxsysz3;
  logic signed [63:0] cycz3, cysz3, sxcy3, cxcy3, sxsz3, cxcz3, sxcz3, cxsz3;
  logic signed [31:0] sy3;

  assign sxsy_rt = (sxsy1 + 64'sd536870912) >>> 30;
  assign cxsy_rt = (cxsy1 + 64'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy1 <= rx.s * ry.s;
      cxsy1 <= rx.c * ry.s;
      cycz1 <= ry.c * rz.c;
      cysz1 <= ry.c * rz.s;
      sxcy1 <= rx.s * ry.c;
      cxcy1 <= rx.c * ry.c;
      sxsz1 <= rx.s * rz.s;
      cxcz1 <= rx.c * rz.c;
      sxcz1 <= rx.s * rz.c;
      cxsz1 <= rx.c * rz.s;
      sy1   <= ry.s;
      cz1   <= rz.c;
      sz1   <= rz.s;

      sxsy2 <= sxsy_rt[33:0];
      cxsy2 <= cxsy_rt[33:0];
      cycz2 <= cycz1;
      cysz2 <= cysz1;
      sxcy2 <= sxcy1;
      cxcy2 <= cxcy1;
      sxsz2 <= sxsz1;
      cxcz2 <= cxcz1;
      sxcz2 <= sxcz1;
      cxsz2 <= cxsz1;
      sy2   <= sy1;
      cz2   <= cz1;
      sz2   <= sz1;

      sxsycz3 <= 66'(sxsy2) * 66'(cz2);
      sxsysz3 <= 66'(sxsy2) * 66'(sz2);
      cxsycz3 <= 66'(cxsy2) * 66'(cz2);
      cxsysz3 <= 66'(cxsy2) * 66'(sz2);
      cycz3   <= cycz2;
      cysz3   <= cysz2;
      sxcy3   <= sxcy2;
      cxcy3   <= cxcy2;
      sxsz3   <= sxsz2;
      cxcz3   <= cxcz2;
      sxcz3   <= sxcz2;
      cxsz3   <= cxsz2;
      sy3     <= sy2;

      axes.left_x <= eatra_pkg::to_q15(66'(cycz3));
      axes.left_y <= eatra_pkg::to_q15(sxsycz3 + 66'(cxsz3));
      axes.left_z <= eatra_pkg::to_q15(66'(sxsz3) - cxsycz3);
      axes.up_x   <= eatra_pkg::to_q15(-66'(cysz3));
      axes.up_y   <= eatra_pkg::to_q15(66'(cxcz3) - sxsysz3);
      axes.up_z   <= eatra_pkg::to_q15(cxsysz3 + 66'(sxcz3));
      axes.fwd_x  <= eatra_pkg::to_q15(66'(sy3) <<< 30);
      axes.fwd_y  <= eatra_pkg::to_q15(-66'(sxcy3));
      axes.fwd_z  <= eatra_pkg::to_q15(66'(cxcy3));
    end
  end

endmodule

// ===== rtl/euler_angles_to_rotation_axes_top.sv =====
// ---------------------------------------------------------------------------
// euler_angles_to_rotation_axes_top
// Pitch, yaw and roll in 1/64 degree to the left, up and forward axes.
// ---------------------------------------------------------------------------
// Each request carries three angles (about X, Y, Z) in 1/64 degree; any
// 16-bit pattern is accepted and reduced modulo a full turn. The block
// returns one result per request: the columns of Rx*Ry*Rz as nine Q1.15
// values, with +1.0 saturating to 32767. It is a fully pipelined stream:
// one request can enter every cycle unless the output stalls. The pipe is
// made of three phase stages, one stage per CORDIC step plus a quadrant
// stage, and four product/rounding stages. A stall on the output freezes
// the whole pipe; s_tready follows m_tready whenever the output register
// is full.
`include "euler_angles_to_rotation_axes_top_macros.svh"

module euler_angles_to_rotation_axes_top #(
  parameter int CORDIC_STEPS = 16    // 8..24, values above 24 act as 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,      // pitch_deg, yaw_deg, roll_deg
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata       // left_x/y/z, up_x/y/z, fwd_x/y/z
);

  localparam int STEPS = (CORDIC_STEPS > eatra_pkg::ATAN_ENTRIES) ?
                         eatra_pkg::ATAN_ENTRIES : CORDIC_STEPS;

  logic               en;
  logic [2:0]         ph_valid;
  logic [31:0]        ph [3];
  logic [2:0]         cs_valid;
  eatra_pkg::sincos_t cs [3];
  eatra_pkg::axes_t   axes;
  logic               in_fire;

  // pipe advances whenever the output slot is free or being drained
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign in_fire  = s_tvalid && s_tready;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    eatra_phase u_phase (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (in_fire),
      .angle     ($signed(s_tdata[16*g +: 16])),
      .out_valid (ph_valid[g]),
      .phase     (ph[g])
    );

    eatra_cordic #(
      .STEPS (STEPS)
    ) u_cordic (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (ph_valid[g]),
      .phase     (ph[g]),
      .out_valid (cs_valid[g]),
      .result    (cs[g])
    );
  end

  // all three lanes run in lockstep; lane 0 carries the request valid
  eatra_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cs_valid[0]),
    .rx        (cs[0]),
    .ry        (cs[1]),
    .rz        (cs[2]),
    .out_valid (m_tvalid),
    .axes      (axes)
  );

  assign m_tdata = axes;

  // lanes never drift apart
  `EATRA_ASSERT_IMPL(a_lanes_aligned, clk, rst, 1'b1, (ph_valid[0] == ph_valid[1]) && (ph_valid[1] == ph_valid[2]) && (cs_valid[0] == cs_valid[1]) && (cs_valid[1] == cs_valid[2]))
  // a stall freezes the pipe state
  `EATRA_ASSERT_NEXT(a_stall_freeze, clk, rst, !en, $stable(ph_valid) && $stable(cs_valid))
  // reset empties the output
  `EATRA_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stream test of the Euler angle to rotation axes block: random and edge
// angle triples, random source bursts and sink stalls, predicted axes.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS     = 16;
  localparam int TURN      = 23040;
  localparam int ATAN_N    = 24;
  localparam longint GAIN  = 64'sd652032874;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [47:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;

  euler_angles_to_rotation_axes_top #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata),           // pitch_deg, yaw_deg, roll_deg
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)            // left_x/y/z, up_x/y/z, fwd_x/y/z
  );

  // angle triples waiting to go out, and axes expected back
  logic [47:0]  angle_queue[$];
  logic [143:0] axes_queue[$];
  int           fail_count = 0;
  bit           stim_done = 0;

  longint atan_lut[ATAN_N] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // floor shift on 64-bit signed
  function automatic longint fshr(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic logic [15:0] q15_of(longint v60);
    longint r;
    r = fshr(v60 + (64'sd1 <<< 44), 45);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // sine and cosine in Q2.30 of one angle in 1/64 degree
  function automatic void angle_trig(input logic [15:0] raw, output longint s,
                                     output longint c);
    longint a, x, y, z, nx, ny;
    logic [63:0] ph;
    logic [1:0] quad;
    a = longint'($signed(raw)) % TURN;
    if (a < 0) a += TURN;
    ph = ((a << 32) + TURN / 2) / TURN;
    quad = ph[31:30];
    z = longint'(ph[29:0]);
    x = GAIN;
    y = 0;
    for (int i = 0; i < STEPS && i < ATAN_N; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i); ny = y + fshr(x, i); z -= atan_lut[i];
      end else begin
        nx = x + fshr(y, i); ny = y - fshr(x, i); z += atan_lut[i];
      end
      x = nx; y = ny;
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [143:0] predict_axes(logic [47:0] ang);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    eatra_pkg::axes_t r;
    angle_trig(ang[15:0], sx, cx);
    angle_trig(ang[31:16], sy, cy);
    angle_trig(ang[47:32], sz, cz);
    sxsy = fshr(sx * sy + (64'sd1 <<< 29), 30);
    cxsy = fshr(cx * sy + (64'sd1 <<< 29), 30);
    r.left_x = q15_of(cy * cz);
    r.left_y = q15_of(sxsy * cz + cx * sz);
    r.left_z = q15_of(-(cxsy * cz) + sx * sz);
    r.up_x   = q15_of(-(cy * sz));
    r.up_y   = q15_of(-(sxsy * sz) + cx * cz);
    r.up_z   = q15_of(cxsy * sz + sx * cz);
    r.fwd_x  = q15_of(sy * (64'sd1 <<< 30));
    r.fwd_y  = q15_of(-(sx * cy));
    r.fwd_z  = q15_of(cx * cy);
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Stimulus: edge angles first, then mostly legal random triples with
  // some full-range 16-bit patterns to exercise the modulo reduction.
  initial begin
    static logic [15:0] edges[14] = '{16'h0000, 16'd23040, -16'sd23040, 16'd5760,
      -16'sd5760, 16'd11520, -16'sd11520, 16'd17280, 16'h7fff, 16'h8000,
      16'hffff, 16'd1, 16'd2880, -16'sd9728};
    logic [15:0] p, y, r;
    for (int i = 0; i < 14; i++)
      angle_queue.push_back({edges[(i + 5) % 14], edges[(i + 3) % 14], edges[i]});
    for (int i = 0; i < 8; i++)
      angle_queue.push_back({edges[$urandom_range(13)], edges[$urandom_range(13)],
                             edges[$urandom_range(13)]});
    for (int i = 0; i < 1800; i++) begin
      if ($urandom_range(9) == 0) begin
        p = 16'($urandom); y = 16'($urandom); r = 16'($urandom);
      end else begin
        p = 16'($urandom_range(46080) - 23040);
        y = 16'($urandom_range(46080) - 23040);
        r = 16'($urandom_range(46080) - 23040);
      end
      angle_queue.push_back({r, y, p});
    end
    stim_done = 1;
  end

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) axes_queue.push_back(predict_axes(s_tdata));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (angle_queue.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= angle_queue.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(40, 1);
          gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink stall pattern: alternates open stretches with choppy ones.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) m_tready <= 1'b1;
      else if (stall_phase < 200) m_tready <= ($urandom_range(3) != 0);
      else m_tready <= ($urandom_range(3) == 0);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    eatra_pkg::axes_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (axes_queue.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = axes_queue.pop_front();
        if (got.left_x !== want.left_x || got.left_y !== want.left_y ||
            got.left_z !== want.left_z || got.up_x !== want.up_x ||
            got.up_y !== want.up_y || got.up_z !== want.up_z ||
            got.fwd_x !== want.fwd_x || got.fwd_y !== want.fwd_y ||
            got.fwd_z !== want.fwd_z) begin
          $display("%0t: axes mismatch expected %h actual %h", $time, want, got);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && angle_queue.size() == 0);
    @(posedge clk);
    while (s_tvalid || axes_queue.size() != 0) @(posedge clk);
    repeat (STEPS + 20) @(posedge clk);
    if (fail_count == 0 && axes_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/eatra_pkg.sv
rtl/eatra_phase.sv
rtl/eatra_cordic.sv
rtl/eatra_matrix.sv
rtl/euler_angles_to_rotation_axes_top.sv
test/tb.sv
